[hw/rtl/sma_pkg.sv]
package sma_pkg;

  localparam int MAX_WINDOW = 64;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 22;
  localparam int AVG_W    = 24;
  localparam int WIN_W    = 7;
  localparam int FRAC_W   = 8;

  localparam int SLOT_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int EFF_W    = $clog2(MAX_WINDOW + 1);
  localparam int TOTAL_W  = SAMPLE_W + $clog2(MAX_WINDOW + 1);
  localparam int DIVD_W   = TOTAL_W + FRAC_W;
  localparam int CNT_W    = $clog2(DIVD_W + 1);

  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 64;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(3);

  typedef struct packed {
    logic                rd_en;
    logic                wr_en;
    logic                clear;
    logic [SLOT_W-1:0]   addr;
    logic [SAMPLE_W-1:0] wdata;
  } ring_req_t;

endpackage

[hw/rtl/sma_ring.sv]
module sma_ring (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sma_pkg::ring_req_t           req_i,
  output logic [sma_pkg::SAMPLE_W-1:0] rd_data_o
);

  logic [sma_pkg::SAMPLE_W-1:0] mem [sma_pkg::MAX_WINDOW];
  logic [sma_pkg::MAX_WINDOW-1:0] valid_q;
  logic [sma_pkg::SAMPLE_W-1:0] rdata_q;
  logic                         rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  // an entry not written since the last clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rvalid_q <= valid_q[req_i.addr];
      end
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

[hw/rtl/sma_div.sv]
module sma_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sma_pkg::DIVD_W-1:0] dividend_i,
  input  logic [sma_pkg::EFF_W-1:0]  divisor_i,
  output logic                       busy_o,
  output logic [sma_pkg::DIVD_W-1:0] quotient_o
);

  logic                       busy_q;
  logic [sma_pkg::CNT_W-1:0]  cnt_q;
  logic [sma_pkg::DIVD_W-1:0] acc_q;
  logic [sma_pkg::EFF_W-1:0]  rem_q;
  logic [sma_pkg::EFF_W-1:0]  dvs_q;
  logic [sma_pkg::EFF_W:0]    trial;
  logic [sma_pkg::EFF_W:0]    diff;

  // restoring divide, one quotient bit per cycle, shifted into acc_q
  assign trial = {rem_q, acc_q[sma_pkg::DIVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= sma_pkg::CNT_W'(sma_pkg::DIVD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - sma_pkg::CNT_W'(1);
      if (cnt_q == sma_pkg::CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[sma_pkg::EFF_W]) begin
        rem_q <= diff[sma_pkg::EFF_W-1:0];
      end else begin
        rem_q <= trial[sma_pkg::EFF_W-1:0];
      end
      acc_q <= {acc_q[sma_pkg::DIVD_W-2:0], ~diff[sma_pkg::EFF_W]};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = acc_q;

endmodule

[hw/rtl/sensor_moving_average.sv]
// Boxcar moving average over the last window_size 16-bit converter samples.
// Slave stream: one sample per transfer. Master stream: one result per
// sample, holding the sample, the exact window sum and the average in
// unsigned Q8, truncated. Window register at APB address 0; a write clears
// the sample ring, the write slot and the running sum. Write it only while
// the block is idle.
// Flow: tready is high only while idle. The transfer in also reads the
// oldest ring entry; the next cycle updates the sum and ring and starts the
// bit-serial divider, which gives one quotient bit per cycle; the divide
// state waits for it to finish and the output state then loads the output
// register. A new sample is taken only once the block is back in idle. A
// window of zero skips the ring and the divider and goes from idle straight
// to the output state, which loads the output register.
// The output register decouples the two sides: a new sample is taken while
// the last result waits; if the receiver still stalls when the next result
// is ready, the block holds it and stays busy.
// Reset: window 3, ring reads as all zeros (valid bits cleared at once),
// sum and slot zero; no clearing pass is needed.
module sensor_moving_average (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample [15:0]
  input  logic [sma_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // sample_echo [15:0], window_sum [37:16], average_q8 [61:38], zero [63:62]
  output logic [sma_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [sma_pkg::PADDR_W-1:0]         paddr_i,
  input  logic [sma_pkg::PDATA_W-1:0]         pwdata_i,
  output logic [sma_pkg::PDATA_W-1:0]         prdata_o,
  output logic                                pready_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                     state_q, state_d;
  logic [sma_pkg::WIN_W-1:0]      window_q;
  logic [sma_pkg::EFF_W-1:0]      eff;
  logic [sma_pkg::SLOT_W-1:0]     slot_q, slot_next;
  logic [sma_pkg::TOTAL_W-1:0]    total_q, total_d;
  logic [sma_pkg::SAMPLE_W-1:0]   sample_q;
  logic                           zero_win_q;
  logic                           cfg_wr;
  logic                           in_xfer;
  logic                           out_load;
  logic                           m_tvalid_q;
  logic [sma_pkg::SAMPLE_W-1:0]   echo_q;
  logic [sma_pkg::SUM_W-1:0]      sum_q;
  logic [sma_pkg::AVG_W-1:0]      avg_q;
  logic [sma_pkg::SAMPLE_W-1:0]   old_sample;
  sma_pkg::ring_req_t             ring_req;
  logic                           div_start;
  logic                           div_busy;
  logic [sma_pkg::DIVD_W-1:0]     quotient;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && !paddr_i[2];
  assign prdata_o = paddr_i[2] ? '0 : sma_pkg::PDATA_W'(window_q);

  assign eff = (32'(window_q) > sma_pkg::MAX_WINDOW) ? sma_pkg::EFF_W'(sma_pkg::MAX_WINDOW)
                                                     : sma_pkg::EFF_W'(window_q);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == ST_OUT) && (!m_tvalid_q || m_axis_tready_i);

  assign slot_next = (32'(slot_q) + 1 >= 32'(eff)) ? '0 : slot_q + sma_pkg::SLOT_W'(1);
  assign total_d   = total_q - sma_pkg::TOTAL_W'(old_sample) + sma_pkg::TOTAL_W'(sample_q);
  assign div_start = (state_q == ST_UPD);

  always_comb begin
    ring_req.rd_en = in_xfer && (eff != '0);
    ring_req.wr_en = (state_q == ST_UPD);
    ring_req.clear = cfg_wr;
    ring_req.addr  = slot_q;
    ring_req.wdata = sample_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = (eff == '0) ? ST_OUT : ST_UPD;
        end
      end
      ST_UPD: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      window_q   <= sma_pkg::WINDOW_RESET;
      slot_q     <= '0;
      total_q    <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        window_q <= pwdata_i[sma_pkg::WIN_W-1:0];
        slot_q   <= '0;
        total_q  <= '0;
      end else if (state_q == ST_UPD) begin
        slot_q  <= slot_next;
        total_q <= total_d;
      end
      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sample_q   <= s_axis_tdata_i[sma_pkg::SAMPLE_W-1:0];
      zero_win_q <= (eff == '0);
    end
    if (state_q == ST_UPD) begin
      sum_q <= total_d[sma_pkg::SUM_W-1:0];
    end
    if (out_load) begin
      echo_q <= sample_q;
      if (zero_win_q) begin
        // pass-through: no ring update, sum reads as zero
        avg_q <= {sample_q, {sma_pkg::FRAC_W{1'b0}}};
      end else begin
        avg_q <= quotient[sma_pkg::AVG_W-1:0];
      end
    end
  end

  logic [sma_pkg::SUM_W-1:0] sum_out;
  assign sum_out = zero_win_q ? '0 : sum_q;

  // sum_out follows zero_win_q, which only changes on a new transfer in;
  // capture it with the rest of the result
  logic [sma_pkg::SUM_W-1:0] sum_out_q;
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sum_out_q <= sum_out;
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = {2'b00, avg_q, sum_out_q, echo_q};

  sma_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ring_req),
    .rd_data_o (old_sample)
  );

  sma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sma_pkg::FRAC_W'(0), total_d} << sma_pkg::FRAC_W),
    .divisor_i  (eff),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  a_ready_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !div_busy)
    else $error("input ready while divider busy");

  a_slot_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eff != '0) |-> (32'(slot_q) < 32'(eff)))
    else $error("write slot outside window");

  a_cfg_clears_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (total_q == '0) && (slot_q == '0))
    else $error("window write did not clear state");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int          SAMPLE_W     = sma_pkg::SAMPLE_W;
  localparam int          SUM_W        = sma_pkg::SUM_W;
  localparam int          AVG_W        = sma_pkg::AVG_W;
  localparam int          RING_DEPTH   = sma_pkg::MAX_WINDOW;
  localparam int unsigned WINDOW_REG   = 0;
  localparam int unsigned SPARE_REG    = 1;  // no register decoded here
  localparam int          SETTLE_CYC   = 40;
  localparam int          LIMIT_CYC    = 1_000_000;
  localparam int          PHASE_ITEMS  = 92;

  typedef struct packed {
    logic [AVG_W-1:0]    average_q8;
    logic [SUM_W-1:0]    window_sum;
    logic [SAMPLE_W-1:0] sample_echo;
  } average_result_t;

  // Boxcar average predictor and store of pending averages
  class boxcar_scoreboard;
    logic [SAMPLE_W-1:0] ring [RING_DEPTH];
    int unsigned         slot;
    logic [SUM_W-1:0]    total;
    int unsigned         window_reg;
    average_result_t     pending_avgs [$];
    int                  errors;

    function new();
      window_reg = 3;
      errors     = 0;
      clear_window();
    endfunction

    function void clear_window();
      foreach (ring[i]) ring[i] = '0;
      slot  = 0;
      total = '0;
    endfunction

    function void write_register(int unsigned idx, logic [31:0] value);
      if (idx != WINDOW_REG) return;
      window_reg = value[6:0];
      clear_window();
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s);
      int unsigned     w;
      logic [31:0]     scaled;
      average_result_t r;
      w = (window_reg > RING_DEPTH) ? RING_DEPTH : window_reg;
      r.sample_echo = s;
      if (w == 0) begin
        r.window_sum = '0;
        scaled       = 32'(s) << 8;
        r.average_q8 = scaled[AVG_W-1:0];
      end else begin
        if (slot >= w) slot = 0;
        total      = total - SUM_W'(ring[slot]) + SUM_W'(s);
        ring[slot] = s;
        slot++;
        if (slot >= w) slot = 0;
        r.window_sum = total;
        scaled       = (32'(total) << 8) / w;
        r.average_q8 = scaled[AVG_W-1:0];
      end
      pending_avgs.push_back(r);
    endfunction

    function void check_result(logic [63:0] data);
      average_result_t got, want;
      got = data[$bits(average_result_t)-1:0];
      if (pending_avgs.size() == 0) begin
        $display("%0t: result with nothing pending, actual %h", $time, data);
        errors++;
        return;
      end
      want = pending_avgs.pop_front();
      if (got.sample_echo !== want.sample_echo) begin
        $display("%0t: sample_echo expected %h actual %h", $time, want.sample_echo,
                 got.sample_echo);
        errors++;
      end
      if (got.window_sum !== want.window_sum) begin
        $display("%0t: window_sum expected %h actual %h", $time, want.window_sum,
                 got.window_sum);
        errors++;
      end
      if (got.average_q8 !== want.average_q8) begin
        $display("%0t: average_q8 expected %h actual %h", $time, want.average_q8,
                 got.average_q8);
        errors++;
      end
    endfunction

    function int pending();
      return pending_avgs.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic [sma_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i;   // sample [15:0]
  logic                          s_axis_tvalid_i;
  logic                          s_axis_tready_o;
  // sample_echo [15:0], window_sum [37:16], average_q8 [61:38], zero [63:62]
  logic [sma_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i;
  logic                          psel_i;
  logic                          penable_i;
  logic                          pwrite_i;
  logic [sma_pkg::PADDR_W-1:0]   paddr_i;
  logic [sma_pkg::PDATA_W-1:0]   pwdata_i;
  logic [sma_pkg::PDATA_W-1:0]   prdata_o;
  logic                          pready_o;

  boxcar_scoreboard sb = new();
  int               send_idle_pct;
  int               recv_stall_pct;
  int               cycle_count;
  int               run_left;
  logic [SAMPLE_W-1:0] run_value;

  sensor_moving_average uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .psel_i          (psel_i),
    .penable_i       (penable_i),
    .pwrite_i        (pwrite_i),
    .paddr_i         (paddr_i),
    .pwdata_i        (pwdata_i),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYC) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver: random back-pressure, checked at the rising edge
  always @(negedge clk_i) begin
    m_axis_tready_i = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = s;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_sample(s);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic drain_results();
    stop_sending();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // write only once the block is idle; a window write clears the ring
  task automatic apb_write(input int unsigned idx, input logic [31:0] value);
    drain_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
    psel_i    = 1'b1;
    penable_i = 1'b0;
    pwrite_i  = 1'b1;
    paddr_i   = sma_pkg::PADDR_W'(4 * idx);
    pwdata_i  = value;
    @(negedge clk_i);
    penable_i = 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    sb.write_register(idx, value);
    @(negedge clk_i);
    psel_i    = 1'b0;
    penable_i = 1'b0;
    pwrite_i  = 1'b0;
  endtask

  // mostly random readings, with long runs of one value to fill the window
  function automatic logic [SAMPLE_W-1:0] next_sample();
    if (run_left == 0 && $urandom_range(15) == 0) begin
      run_left = $urandom_range(90, 10);
      case ($urandom_range(2))
        0:       run_value = '0;
        1:       run_value = '1;
        default: run_value = SAMPLE_W'($urandom);
      endcase
    end
    if (run_left > 0) begin
      run_left--;
      return run_value;
    end
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned windows [12];
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    psel_i          = 1'b0;
    penable_i       = 1'b0;
    pwrite_i        = 1'b0;
    paddr_i         = '0;
    pwdata_i        = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    cycle_count     = 0;
    run_left        = 0;
    run_value       = '0;
    windows = '{1, 64, 0, 127, 2, 65, 7, 33, $urandom_range(127), 64,
                $urandom_range(1, 64), 16};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset window of three: full-scale sum, then zeros and mid-scale
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    // undecoded address: window and ring stay as they are
    apb_write(SPARE_REG, 32'h0000_0000);
    send_sample(16'h1234);
    send_sample(16'h0000);
    // zero window passes the sample through
    apb_write(WINDOW_REG, 32'd0);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'hA5A5);
    apb_write(WINDOW_REG, 32'd1);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    // above the ring depth the window saturates
    apb_write(WINDOW_REG, 32'd127);
    send_sample(16'hFFFF);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    apb_write(WINDOW_REG, 32'd65);
    send_sample(16'hFFFF);
    apb_write(WINDOW_REG, 32'd64);
    send_sample(16'hFFFF);
    send_sample(16'h00FF);

    for (int p = 0; p < 12; p++) begin
      apb_write(WINDOW_REG, windows[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == PHASE_ITEMS / 2) drain_results();
        send_sample(next_sample());
      end
    end

    drain_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
